FILE: sv/rqct_pkg.sv
// shared types and constants of the resource quota counter table
package rqct_pkg;

	localparam int USAGE_W = 40;
	localparam int THR_W   = 32;
	localparam int FAIL_W  = 32;
	localparam int AMT_W   = 32;
	localparam int RES_W   = 5;
	// wide enough to compare an entry index against a table of up to 256 entries
	localparam int CNT_CMP_W = 9;

	localparam logic [THR_W-1:0]   THRESH_RESET = 32'd2147483647;
	localparam logic [USAGE_W-1:0] USAGE_MAX    = '1;

	// action codes; unlisted codes behave as read
	localparam logic [2:0] ACT_CHARGE      = 3'd0;
	localparam logic [2:0] ACT_UNCHARGE    = 3'd1;
	localparam logic [2:0] ACT_READ        = 3'd2;
	localparam logic [2:0] ACT_SET_BARRIER = 3'd3;
	localparam logic [2:0] ACT_SET_LIMIT   = 3'd4;

	// charge severity codes; the unused code is checked like hard
	localparam logic [1:0] SEV_HARD  = 2'd0;
	localparam logic [1:0] SEV_SOFT  = 2'd1;
	localparam logic [1:0] SEV_FORCE = 2'd2;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_INVALID      = 3'd1,
		ST_OVER_BARRIER = 3'd2,
		ST_OVER_LIMIT   = 3'd3,
		ST_CLAMPED      = 3'd4
	} status_t;

	typedef struct packed {
		logic [USAGE_W-1:0] usage;
		logic [USAGE_W-1:0] peak;
		logic [THR_W-1:0]   barrier;
		logic [THR_W-1:0]   hard;
		logic [FAIL_W-1:0]  fails;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		usage:   '0,
		peak:    '0,
		barrier: THRESH_RESET,
		hard:    THRESH_RESET,
		fails:   '0
	};

	typedef struct packed {
		logic [2:0]       action;
		logic [AMT_W-1:0] amount;
		logic [1:0]       severity;
		logic             test_only;
	} req_t;

	// config register indexes
	localparam logic REG_MAX_VALUE = 1'b0;

endpackage

FILE: sv/rqct_mem.sv
// entry memory with per-entry valid bits and write-to-read forwarding
module rqct_mem #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_idx,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_idx,
	input  rqct_pkg::entry_t  wr_data,
	output rqct_pkg::entry_t  rd_data
);
	import rqct_pkg::*;

	entry_t             mem [DEPTH];
	entry_t             ram_q;
	entry_t             fwd_data_q;
	logic [DEPTH-1:0]   valid_q;
	logic               vld_s1;
	logic               fwd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			ram_q      <= mem[rd_idx];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
			fwd_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= valid_q[rd_idx];
				// a write to the same entry at the read edge is not yet in ram_q
				fwd_s1 <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	// never-written entries read as their reset value
	assign rd_data = fwd_s1 ? fwd_data_q : (vld_s1 ? ram_q : ENTRY_RESET);

endmodule

FILE: sv/rqct_alu.sv
// update logic for one entry: charge, uncharge, set and read
module rqct_alu (
	input  rqct_pkg::req_t     req,
	input  rqct_pkg::entry_t   cur,
	input  logic [31:0]        max_value,
	output rqct_pkg::entry_t   nxt,
	output rqct_pkg::status_t  status
);
	import rqct_pkg::*;

	logic [USAGE_W:0]   sum;
	logic [USAGE_W-1:0] sat;
	logic [USAGE_W-1:0] amt_ext;
	logic               over_soft;
	logic               over_hard;
	logic               too_big;

	assign amt_ext   = USAGE_W'(req.amount);
	assign sum       = {1'b0, cur.usage} + {1'b0, amt_ext};
	assign sat       = sum[USAGE_W] ? USAGE_MAX : sum[USAGE_W-1:0];
	assign over_soft = sum > (USAGE_W+1)'(cur.barrier);
	assign over_hard = sum > (USAGE_W+1)'(cur.hard);
	assign too_big   = req.amount > max_value;

	always_comb begin
		nxt    = cur;
		status = ST_OK;
		case (req.action)
			ACT_CHARGE: begin
				if (too_big) begin
					status = ST_INVALID;
				end else begin
					if (req.severity != SEV_FORCE) begin
						if (req.severity != SEV_SOFT && over_soft) begin
							status = ST_OVER_BARRIER;
						end else if (over_hard) begin
							status = ST_OVER_LIMIT;
						end
					end
					if (status != ST_OK) begin
						if (!req.test_only) begin
							nxt.fails = cur.fails + 1'b1;
						end
					end else begin
						nxt.usage = sat;
						if (sat > cur.peak) begin
							nxt.peak = sat;
						end
					end
				end
			end
			ACT_UNCHARGE: begin
				if (cur.usage < amt_ext) begin
					nxt.usage = '0;
					status    = ST_CLAMPED;
				end else begin
					nxt.usage = cur.usage - amt_ext;
				end
			end
			ACT_SET_BARRIER: begin
				if (too_big) begin
					status = ST_INVALID;
				end else begin
					nxt.barrier = req.amount;
				end
			end
			ACT_SET_LIMIT: begin
				if (too_big) begin
					status = ST_INVALID;
				end else begin
					nxt.hard = req.amount;
				end
			end
			default: begin
				// read and unused codes leave the entry as it is
				nxt = cur;
			end
		endcase
	end

endmodule

FILE: sv/resource_quota_counter_table_unit.sv
// top level of the resource quota counter table
//
//   port group   direction  handshake               payload
//   in           sink       in_valid / in_ready     action resource amount severity test_only
//   out          source     out_valid / out_ready   status held max_held barrier limit
//                                                   fail_count
//   apb config   slave      psel penable pwrite     paddr pwdata prdata pready
//
// one item per cycle sustained while out_ready stays high; the accepting edge reads
// the entry memory into the update stage, and when that stage advances the update is
// registered into the output register and written back
// back-to-back items to the same entry see the previous write through forwarding
// reset clears the per-entry valid bits at once, so no clearing pass is needed;
// max_value resets to 2147483647
// with a result waiting and out_ready low the update stage holds and in_ready drops
module resource_quota_counter_table_unit #(
	parameter int NUM_COUNTERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [4:0]  resource,
	input  logic [31:0] amount,
	input  logic [1:0]  severity,
	input  logic        test_only,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [39:0] held,
	output logic [39:0] max_held,
	output logic [31:0] barrier,
	output logic [31:0] limit,
	output logic [31:0] fail_count,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rqct_pkg::*;

	localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

	// config register
	logic [31:0] max_value_q;

	// update stage (memory read data is valid here)
	logic             s1_valid;
	req_t             req_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             inrange_s1;
	logic             s1_adv;

	// output register
	logic          out_valid_q;
	status_t       status_q;
	entry_t        res_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic             in_range;
	entry_t           cur;
	entry_t           nxt;
	status_t          alu_status;

	// apb: always ready, write on access phase, address bit 2 picks the register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_VALUE) ? max_value_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_VALUE) begin
			max_value_q <= pwdata;
		end
	end

	// the update stage drains whenever the output register is free or being taken
	assign s1_adv   = s1_valid && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid || s1_adv;
	assign rd_en    = in_valid && in_ready;
	assign rd_idx   = IDX_W'(resource);
	assign in_range = CNT_CMP_W'(resource) < CNT_CMP_W'(NUM_COUNTERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (rd_en) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			req_s1     <= '{action: action, amount: amount, severity: severity,
			                test_only: test_only};
			idx_s1     <= rd_idx;
			inrange_s1 <= in_range;
		end
	end

	rqct_mem #(
		.DEPTH (NUM_COUNTERS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.wr_en   (s1_adv && inrange_s1),
		.wr_idx  (idx_s1),
		.wr_data (nxt),
		.rd_data (cur)
	);

	rqct_alu u_alu (
		.req       (req_s1),
		.cur       (cur),
		.max_value (max_value_q),
		.nxt       (nxt),
		.status    (alu_status)
	);

	// output register; an index beyond the table reports invalid with zeroed counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (inrange_s1) begin
				status_q <= alu_status;
				res_q    <= nxt;
			end else begin
				status_q <= ST_INVALID;
				res_q    <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign held       = res_q.usage;
	assign max_held   = res_q.peak;
	assign barrier    = res_q.barrier;
	assign limit      = res_q.hard;
	assign fail_count = res_q.fails;

	// an accepted item always occupies the update stage next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> s1_valid)
		else $error("accepted item did not reach the update stage");

	// usage never rises above the recorded peak
	a_held_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> held <= max_held)
		else $error("held above max_held");

	// a clamped uncharge leaves the entry empty
	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CLAMPED |-> held == '0)
		else $error("clamped uncharge with nonzero held");

	// a stalled update stage blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while update stage stalled");

endmodule

FILE: verif/resource_quota_counter_table_unit_tb.sv
// testbench for the resource quota counter table: directed and random requests checked against a predictor
module resource_quota_counter_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rqct_pkg::*;

	localparam int NUM_COUNTERS = 32;
	// idle clocks after the last result, to leave some slack before register writes
	localparam int DRAIN_CYCLES = 8;
	// limit on the whole run, checked by the watchdog
	localparam int RUN_LIMIT = 500000;

	// action and severity codes the package leaves unnamed; they act as read and as hard
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	localparam logic [1:0] SEV_SPARE       = 2'd3;

	// one result item as the block should report it
	typedef struct packed {
		status_t     status;
		logic [39:0] held;
		logic [39:0] max_held;
		logic [31:0] barrier;
		logic [31:0] limit;
		logic [31:0] fail_count;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [4:0]  resource = '0;
	logic [31:0] amount = '0;
	logic [1:0]  severity = '0;
	logic        test_only = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [39:0] held;
	logic [39:0] max_held;
	logic [31:0] barrier;
	logic [31:0] limit;
	logic [31:0] fail_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	resource_quota_counter_table_unit #(
		.NUM_COUNTERS(NUM_COUNTERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.resource(resource),
		.amount(amount),
		.severity(severity),
		.test_only(test_only),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.held(held),
		.max_held(max_held),
		.barrier(barrier),
		.limit(limit),
		.fail_count(fail_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// predictor's own copy of the table and of max_value
	logic [39:0] used_units [NUM_COUNTERS];
	logic [39:0] peak_units [NUM_COUNTERS];
	logic [31:0] barrier_thr [NUM_COUNTERS];
	logic [31:0] limit_thr [NUM_COUNTERS];
	logic [31:0] refusals [NUM_COUNTERS];
	logic [31:0] cap_value = THRESH_RESET;

	// reports still owed by the block, oldest first
	report_t pending_reports [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int cycle_count = 0;
	int status_seen [8];

	// work out one request against the mirrored table, updating it like the block does
	function automatic report_t account_request(input logic [2:0] act, input logic [4:0] res,
			input logic [31:0] amt, input logic [1:0] sev, input logic tst);
		report_t rep;
		logic [40:0] sum;
		rep = '0;
		rep.status = ST_OK;
		// an index past the table answers invalid with all counters zero
		if (int'(res) >= NUM_COUNTERS) begin
			rep.status = ST_INVALID;
			return rep;
		end
		case (act)
			ACT_CHARGE: begin
				if (amt > cap_value) begin
					rep.status = ST_INVALID;
				end else begin
					sum = {1'b0, used_units[res]} + amt;
					// force skips the checks; soft looks at the limit only; barrier wins over limit
					if (sev != SEV_FORCE) begin
						if (sev != SEV_SOFT && sum > barrier_thr[res])
							rep.status = ST_OVER_BARRIER;
						else if (sum > limit_thr[res])
							rep.status = ST_OVER_LIMIT;
					end
					if (rep.status != ST_OK) begin
						if (!tst)
							refusals[res] = refusals[res] + 1;
					end else begin
						// a forced charge saturates usage
						if (sum > {1'b0, USAGE_MAX})
							sum = {1'b0, USAGE_MAX};
						used_units[res] = sum[39:0];
						if (sum[39:0] > peak_units[res])
							peak_units[res] = sum[39:0];
					end
				end
			end
			ACT_UNCHARGE: begin
				// uncharging more than is held clamps at zero
				if (used_units[res] < amt) begin
					used_units[res] = '0;
					rep.status = ST_CLAMPED;
				end else begin
					used_units[res] = used_units[res] - amt;
				end
			end
			ACT_SET_BARRIER, ACT_SET_LIMIT: begin
				if (amt > cap_value)
					rep.status = ST_INVALID;
				else if (act == ACT_SET_BARRIER)
					barrier_thr[res] = amt;
				else
					limit_thr[res] = amt;
			end
			default: ;
		endcase
		rep.held = used_units[res];
		rep.max_held = peak_units[res];
		rep.barrier = barrier_thr[res];
		rep.limit = limit_thr[res];
		rep.fail_count = refusals[res];
		return rep;
	endfunction

	function automatic void check_field(input string name, input logic [39:0] want,
			input logic [39:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// receiver side: random back-pressure at the rate of the current phase
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker: every accepted result item against the oldest pending report
	always @(posedge clk) begin
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$error("result item with no request outstanding: status %0d held 0x%0h",
					status, held);
				mismatch_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", 40'(want.status), 40'(status));
				check_field("held", want.held, held);
				check_field("max_held", want.max_held, max_held);
				check_field("barrier", 40'(want.barrier), 40'(barrier));
				check_field("limit", 40'(want.limit), 40'(limit));
				check_field("fail_count", 40'(want.fail_count), 40'(fail_count));
				checked_count++;
				status_seen[status]++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$error("run exceeded %0d cycles with %0d reports outstanding",
				RUN_LIMIT, pending_reports.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// present one item, holding it until accepted; called at a rising edge
	task automatic send_request(input logic [2:0] act, input logic [4:0] res,
			input logic [31:0] amt, input logic [1:0] sev, input logic tst);
		// sender idle cycles before the item
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		resource <= res;
		amount <= amt;
		severity <= sev;
		test_only <= tst;
		do
			@(posedge clk);
		while (!in_ready);
		// accepted at this edge: predict in acceptance order
		pending_reports.push_back(account_request(act, res, amt, sev, tst));
		sent_count++;
	endtask

	// stop sending and let every owed result come back
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write of max_value while the table is idle, then read it back
	task automatic write_max_value(input logic [31:0] value);
		drain_reports();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_MAX_VALUE, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge
		cap_value = value;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value) begin
			$error("prdata mismatch: expected 0x%0h, got 0x%0h", value, prdata);
			mismatch_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// amounts spread over tiny, threshold-sized, around max_value and full range
	function automatic logic [31:0] random_amount();
		case ($urandom_range(6))
			0: return 32'($urandom_range(64));
			1: return 32'($urandom_range(4096));
			2: return cap_value;
			3: return cap_value + 1;
			4: return $urandom() >> $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	// random mix weighted toward charge and uncharge on a few hot entries
	task automatic run_random_mix(input int count);
		logic [2:0] act;
		logic [4:0] res;
		logic [31:0] amt;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				act = ACT_CHARGE;
			else if (pick < 60)
				act = ACT_UNCHARGE;
			else if (pick < 68)
				act = ACT_READ;
			else if (pick < 78)
				act = ACT_SET_BARRIER;
			else if (pick < 88)
				act = ACT_SET_LIMIT;
			else
				act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
			// hot entries keep usage building up so thresholds actually bite
			res = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom());
			// thresholds mostly small so charges hit them
			if ((act == ACT_SET_BARRIER || act == ACT_SET_LIMIT) && $urandom_range(99) < 60)
				amt = 32'($urandom_range(6000));
			else
				amt = random_amount();
			send_request(act, res, amt, 2'($urandom_range(3)), 1'($urandom_range(1)));
		end
	endtask

	// extremes of every field, every action and each corner of the charge check
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_request(ACT_READ, 5'd0, 32'd0, SEV_HARD, 1'b0);
		send_request(ACT_CHARGE, 5'd1, 32'd0, SEV_HARD, 1'b0);
		send_request(ACT_CHARGE, 5'd1, 32'd100, SEV_HARD, 1'b0);
		send_request(ACT_SET_BARRIER, 5'd1, 32'd150, SEV_HARD, 1'b0);
		send_request(ACT_SET_LIMIT, 5'd1, 32'd200, SEV_HARD, 1'b0);
		// above barrier only, then above both: barrier reported either way
		send_request(ACT_CHARGE, 5'd1, 32'd60, SEV_HARD, 1'b0);
		send_request(ACT_CHARGE, 5'd1, 32'd200, SEV_HARD, 1'b0);
		// hard charge inside the barrier but over the limit
		send_request(ACT_SET_BARRIER, 5'd2, 32'd1000, SEV_HARD, 1'b0);
		send_request(ACT_SET_LIMIT, 5'd2, 32'd50, SEV_HARD, 1'b0);
		send_request(ACT_CHARGE, 5'd2, 32'd60, SEV_HARD, 1'b0);
		// soft ignores the barrier; exactly at the limit passes
		send_request(ACT_CHARGE, 5'd1, 32'd100, SEV_SOFT, 1'b0);
		// refused probe leaves fail_count alone
		send_request(ACT_CHARGE, 5'd1, 32'd1, SEV_SOFT, 1'b1);
		// spare severity behaves like hard
		send_request(ACT_CHARGE, 5'd1, 32'd1, SEV_SPARE, 1'b0);
		send_request(ACT_CHARGE, 5'd1, THRESH_RESET, SEV_FORCE, 1'b0);
		send_request(ACT_UNCHARGE, 5'd1, 32'hFFFF_FFFF, SEV_HARD, 1'b0);
		// amounts above max_value rejected for charge and set barrier; a limit equal to max_value is taken
		send_request(ACT_CHARGE, 5'd3, THRESH_RESET + 1, SEV_FORCE, 1'b0);
		send_request(ACT_SET_BARRIER, 5'd3, 32'hFFFF_FFFF, SEV_HARD, 1'b0);
		send_request(ACT_SET_LIMIT, 5'd3, THRESH_RESET, SEV_HARD, 1'b0);
		// spare actions read the entry
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_request(3'(a), 5'd1, $urandom(), SEV_SPARE, 1'b1);
		send_request(ACT_UNCHARGE, 5'd31, 32'hFFFF_FFFF, SEV_HARD, 1'b0);
		send_request(ACT_UNCHARGE, 5'd31, 32'd0, SEV_HARD, 1'b0);
		// sum equal to both thresholds still passes, one more fails
		send_request(ACT_CHARGE, 5'd31, THRESH_RESET, SEV_HARD, 1'b0);
		send_request(ACT_CHARGE, 5'd31, 32'd1, SEV_HARD, 1'b1);
	endtask

	task automatic test_streaming();
		write_max_value(THRESH_RESET);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_mix(200);
	endtask

	task automatic test_sender_gaps();
		// max_value of 1: almost every charge and set is rejected
		write_max_value(32'd1);
		send_idle_pct = 65;
		recv_stall_pct = 0;
		run_random_mix(200);
	endtask

	task automatic test_receiver_stalls();
		write_max_value(32'hFFFF_FFFF);
		send_idle_pct = 0;
		recv_stall_pct = 65;
		run_random_mix(200);
	endtask

	task automatic test_both_idle();
		write_max_value($urandom_range(32'hFFFF_FFFF, 1));
		send_idle_pct = 31;
		recv_stall_pct = 31;
		run_random_mix(200);
	endtask

	// forced charges of the largest amount drive one entry into saturation
	task automatic test_usage_saturation();
		logic [4:0] res;
		write_max_value(32'hFFFF_FFFF);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		res = 5'($urandom_range(NUM_COUNTERS - 1, 4));
		for (int i = 0; i < 260; i++)
			send_request(ACT_CHARGE, res, 32'hFFFF_FFFF, SEV_FORCE, 1'($urandom_range(1)));
		send_request(ACT_CHARGE, res, 32'd0, SEV_HARD, 1'b0);
		send_request(ACT_CHARGE, res, 32'd1, SEV_SOFT, 1'b0);
		send_request(ACT_UNCHARGE, res, 32'hFFFF_FFFF, SEV_HARD, 1'b0);
		send_request(ACT_READ, res, 32'd0, SEV_HARD, 1'b0);
	endtask

	initial begin
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			used_units[i] = '0;
			peak_units[i] = '0;
			barrier_thr[i] = THRESH_RESET;
			limit_thr[i] = THRESH_RESET;
			refusals[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_usage_saturation();
		drain_reports();

		$display("sent %0d request items, checked %0d result items over max_value 1, reset, all ones and random",
			sent_count, checked_count);
		$display("statuses ok %0d invalid %0d barrier %0d limit %0d clamped %0d; idling mixes and saturation run",
			status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_OVER_BARRIER],
			status_seen[ST_OVER_LIMIT], status_seen[ST_CLAMPED]);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
